### hw/rtl/chassis_power_current_limiter_macros.svh
// assertion macros used by the checker file of the current limiter
`ifndef CHASSIS_POWER_CURRENT_LIMITER_MACROS_SVH
`define CHASSIS_POWER_CURRENT_LIMITER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CPCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CPCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cpcl_pkg.sv
// shared constants, types and helpers of the chassis current limiter
`default_nettype none

package cpcl_pkg;

    // payload widths
    localparam int LANES      = 4;
    localparam int CUR_W      = 16;
    localparam int PWR_W      = 16;
    localparam int CFG16_W    = 16;
    localparam int CFG18_W    = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int TOT_W      = 18;
    localparam int LIM_W      = 19;

    // divider geometry: one quotient bit per stage
    localparam int NUM_W      = 34;
    localparam int DEN_W      = 18;
    localparam int QUOT_W     = 18;
    localparam int DIV_STAGES = QUOT_W;
    localparam int DIV_CMP_W  = DEN_W + QUOT_W;

    // pipeline latencies in cycles
    localparam int LIM_LAT = DIV_STAGES + 4;
    localparam int OUT_LAT = LIM_LAT + DIV_STAGES + 3;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POWER_CUTOFF   = 3'd0,
        CFG_POWER_KNEE     = 3'd1,
        CFG_WARNING_BUFFER = 3'd2,
        CFG_MIN_BUFFER     = 3'd3,
        CFG_BUFFER_CL      = 3'd4,
        CFG_POWER_CL       = 3'd5,
        CFG_BYPASS_CL      = 3'd6
    } t_cfg_idx;

    // register reset values
    localparam logic [CFG16_W-1:0] RST_POWER_CUTOFF   = 16'd8000;
    localparam logic [CFG16_W-1:0] RST_POWER_KNEE     = 16'd4000;
    localparam logic [CFG16_W-1:0] RST_WARNING_BUFFER = 16'd50;
    localparam logic [CFG16_W-1:0] RST_MIN_BUFFER     = 16'd5;
    localparam logic [CFG18_W-1:0] RST_BUFFER_CL      = 18'd16000;
    localparam logic [CFG18_W-1:0] RST_POWER_CL       = 18'd20000;
    localparam logic [CFG18_W-1:0] RST_BYPASS_CL      = 18'd64000;

    // configuration registers as seen by the limit unit
    typedef struct packed {
        logic [CFG16_W-1:0] power_cutoff;
        logic [CFG16_W-1:0] power_knee;
        logic [CFG16_W-1:0] warning_buffer;
        logic [CFG16_W-1:0] min_buffer;
        logic [CFG18_W-1:0] buffer_cl;
        logic [CFG18_W-1:0] power_cl;
        logic [CFG18_W-1:0] bypass_cl;
    } t_cfg;

    // per-lane work handed from the merge stage to a lane
    typedef struct packed {
        logic             scale;
        logic [TOT_W-1:0] total;
        logic [TOT_W-1:0] lim;
        logic [CUR_W-1:0] cur;
    } t_lane_in;

    // magnitude of a signed current, 32768 included
    function automatic logic [CUR_W-1:0] cpcl_mag(input logic [CUR_W-1:0] cur);
        logic [CUR_W-1:0] v_neg;
        v_neg = CUR_W'(~cur + 1'b1);
        return cur[CUR_W-1] ? v_neg : cur;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cpcl_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module cpcl_div
    import cpcl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic      [QUOT_W-1:0] o_quot
);

    logic [NUM_W-1:0]  r_rem  [DIV_STAGES];
    logic [DEN_W-1:0]  r_den  [DIV_STAGES];
    logic [QUOT_W-1:0] r_quot [DIV_STAGES];

    logic [NUM_W-1:0]  c_rem  [DIV_STAGES];
    logic [DEN_W-1:0]  c_den  [DIV_STAGES];
    logic [QUOT_W-1:0] c_quot [DIV_STAGES];

    logic [NUM_W-1:0]  n_rem  [DIV_STAGES];
    logic [QUOT_W-1:0] n_quot [DIV_STAGES];

    // stage s decides quotient bit QUOT_W-1-s; the numerator must be below den << QUOT_W
    always_comb begin
        logic [DIV_CMP_W-1:0] v_den_sh;
        logic [DIV_CMP_W-1:0] v_rem;
        c_rem[0]  = i_num;
        c_den[0]  = i_den;
        c_quot[0] = '0;
        for (int s = 1; s < DIV_STAGES; s++) begin
            c_rem[s]  = r_rem[s-1];
            c_den[s]  = r_den[s-1];
            c_quot[s] = r_quot[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            v_den_sh = DIV_CMP_W'(c_den[s]) << (QUOT_W - 1 - s);
            v_rem    = DIV_CMP_W'(c_rem[s]);
            if (v_rem >= v_den_sh) begin
                n_rem[s]  = NUM_W'(v_rem - v_den_sh);
                n_quot[s] = {c_quot[s][QUOT_W-2:0], 1'b1};
            end else begin
                n_rem[s]  = c_rem[s];
                n_quot[s] = {c_quot[s][QUOT_W-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_den[s]  <= c_den[s];
            r_quot[s] <= n_quot[s];
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/cpcl_limit.sv
// total current limit: branch select, multiply, saturate, divide
`default_nettype none

module cpcl_limit
    import cpcl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cfg             i_cfg,
    input  wire logic [PWR_W-1:0] i_power,
    input  wire logic [PWR_W-1:0] i_buffer,
    input  wire logic             i_bypass,
    output logic      [LIM_W-1:0] o_limit
);

    typedef struct packed {
        logic               use_div;
        logic               sat;
        logic [CFG18_W-1:0] base;
        logic [LIM_W-1:0]   fixed;
    } t_lim_side;

    // stage 1: operands
    logic               n1_use_div, r1_use_div;
    logic [CFG18_W-1:0] n1_a, r1_a;
    logic [CFG16_W-1:0] n1_b, r1_b;
    logic [CFG16_W-1:0] n1_den, r1_den;
    logic [CFG18_W-1:0] n1_base, r1_base;
    logic [LIM_W-1:0]   n1_fixed, r1_fixed;

    // stage 2: product
    logic [NUM_W-1:0]   r2_prod;
    logic [CFG16_W-1:0] r2_den;
    logic               r2_use_div;
    logic [CFG18_W-1:0] r2_base;
    logic [LIM_W-1:0]   r2_fixed;

    // stage 3: saturation check
    logic [NUM_W-1:0]   r3_num;
    logic [DEN_W-1:0]   r3_den;
    t_lim_side          r3_side;
    logic               w_sat;

    t_lim_side          r_side [DIV_STAGES];
    logic [QUOT_W-1:0]  w_quot;
    logic [QUOT_W-1:0]  w_q_sel;
    logic [LIM_W-1:0]   n_limit, r_limit;

    // pick the branch and its operands
    always_comb begin
        n1_use_div = 1'b0;
        n1_a       = '0;
        n1_b       = '0;
        n1_den     = '0;
        n1_base    = '0;
        n1_fixed   = LIM_W'(i_cfg.buffer_cl) + LIM_W'(i_cfg.power_cl);
        if (i_bypass) begin
            n1_fixed = LIM_W'(i_cfg.bypass_cl);
        end else if (i_buffer < i_cfg.warning_buffer) begin
            n1_use_div = 1'b1;
            n1_a       = i_cfg.buffer_cl;
            n1_b       = (i_buffer > i_cfg.min_buffer) ? i_buffer : i_cfg.min_buffer;
            n1_den     = i_cfg.warning_buffer;
        end else if (i_power > i_cfg.power_knee) begin
            if (i_power < i_cfg.power_cutoff) begin
                n1_use_div = 1'b1;
                n1_a       = i_cfg.power_cl;
                n1_b       = CFG16_W'(i_cfg.power_cutoff - i_power);
                n1_den     = CFG16_W'(i_cfg.power_cutoff - i_cfg.power_knee);
                n1_base    = i_cfg.buffer_cl;
            end else begin
                n1_fixed = LIM_W'(i_cfg.buffer_cl);
            end
        end
    end

    // quotient too wide for the divider: the limit then clears any total
    assign w_sat = r2_prod >= (NUM_W'(r2_den) << QUOT_W);

    always_ff @(posedge i_clk) begin
        r1_use_div <= n1_use_div;
        r1_a       <= n1_a;
        r1_b       <= n1_b;
        r1_den     <= n1_den;
        r1_base    <= n1_base;
        r1_fixed   <= n1_fixed;

        r2_prod    <= NUM_W'(r1_a) * NUM_W'(r1_b);
        r2_den     <= r1_den;
        r2_use_div <= r1_use_div;
        r2_base    <= r1_base;
        r2_fixed   <= r1_fixed;

        r3_num           <= w_sat ? '0 : r2_prod;
        r3_den           <= DEN_W'(r2_den);
        r3_side.use_div  <= r2_use_div;
        r3_side.sat      <= w_sat;
        r3_side.base     <= r2_base;
        r3_side.fixed    <= r2_fixed;
    end

    cpcl_div u_div (
        .i_clk  (i_clk),
        .i_num  (r3_num),
        .i_den  (r3_den),
        .o_quot (w_quot)
    );

    // side data rides along with the divider
    always_ff @(posedge i_clk) begin
        r_side[0] <= r3_side;
        for (int s = 1; s < DIV_STAGES; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    // final limit
    always_comb begin
        w_q_sel = r_side[DIV_STAGES-1].sat ? '1 : w_quot;
        if (r_side[DIV_STAGES-1].use_div) begin
            n_limit = LIM_W'(r_side[DIV_STAGES-1].base) + LIM_W'(w_q_sel);
        end else begin
            n_limit = r_side[DIV_STAGES-1].fixed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
    end

    assign o_limit = r_limit;

endmodule

`default_nettype wire

### hw/rtl/cpcl_lane.sv
// one motor lane: current times limit over total, sign restored
`default_nettype none

module cpcl_lane
    import cpcl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_lane_in         i_work,
    output logic      [CUR_W-1:0] o_limited
);

    logic [NUM_W-1:0]  r_prod;
    logic [DEN_W-1:0]  r_den;
    logic [CUR_W-1:0]  r_cur;
    logic              r_scale;

    logic [CUR_W-1:0]  r_cur_d   [DIV_STAGES];
    logic              r_scale_d [DIV_STAGES];

    logic [QUOT_W-1:0] w_quot;
    logic [CUR_W-1:0]  w_mag;
    logic [CUR_W-1:0]  w_q16;

    assign w_mag = cpcl_mag(i_work.cur);

    // product stage; lim is zero when the lane passes through
    always_ff @(posedge i_clk) begin
        r_prod  <= NUM_W'(w_mag * i_work.lim);
        r_den   <= DEN_W'(i_work.total);
        r_cur   <= i_work.cur;
        r_scale <= i_work.scale;
    end

    cpcl_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_prod),
        .i_den  (r_den),
        .o_quot (w_quot)
    );

    // original command and scale flag follow the divider
    always_ff @(posedge i_clk) begin
        r_cur_d[0]   <= r_cur;
        r_scale_d[0] <= r_scale;
        for (int s = 1; s < DIV_STAGES; s++) begin
            r_cur_d[s]   <= r_cur_d[s-1];
            r_scale_d[s] <= r_scale_d[s-1];
        end
    end

    // scaled magnitude is below the original, so 16 bits hold it
    assign w_q16 = w_quot[CUR_W-1:0];

    always_comb begin
        if (!r_scale_d[DIV_STAGES-1]) begin
            o_limited = r_cur_d[DIV_STAGES-1];
        end else if (r_cur_d[DIV_STAGES-1][CUR_W-1]) begin
            o_limited = CUR_W'(~w_q16 + 1'b1);
        end else begin
            o_limited = w_q16;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/chassis_power_current_limiter.sv
// top level of the chassis power current limiter
//
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low. It carries chassis power, buffer energy, a bypass bit and four signed
//   motor current commands. The block picks a total current limit and, when
//   the summed magnitudes exceed it, scales every command by limit / total.
//   Each result is shown for exactly one cycle with o_valid high; the receiver
//   cannot hold it off, and nothing here needs it to.
//   Throughput: one transaction every cycle; busy is low except during reset.
//   Path from the accepting edge to o_valid: two 18-stage restoring dividers
//   in series, one in the limit unit and one in each motor lane, plus the
//   operand, multiply, saturation and limit registers of the limit unit, the
//   merge register, the lane product registers and the output register.
//   Configuration: i_cfg_we writes register i_cfg_idx at the next edge; writes
//   to index 7 are ignored. Write only while no transaction is in flight.
//   Reset (i_rst_n low, synchronous) restores the register defaults, drops
//   every transaction in flight and holds busy high until the next cycle.
`default_nettype none

module chassis_power_current_limiter
    import cpcl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [PWR_W-1:0]      i_chassis_power,
    input  wire logic [PWR_W-1:0]      i_buffer_energy,
    input  wire logic                  i_bypass,
    input  wire logic signed [CUR_W-1:0] i_current_0,
    input  wire logic signed [CUR_W-1:0] i_current_1,
    input  wire logic signed [CUR_W-1:0] i_current_2,
    input  wire logic signed [CUR_W-1:0] i_current_3,

    output logic                       o_valid,
    output logic signed [CUR_W-1:0]    o_limited_0,
    output logic signed [CUR_W-1:0]    o_limited_1,
    output logic signed [CUR_W-1:0]    o_limited_2,
    output logic signed [CUR_W-1:0]    o_limited_3,
    output logic                       o_was_scaled
);

    t_cfg               r_cfg;
    logic               r_busy;
    logic               w_accept;
    logic [OUT_LAT-1:0] r_vld;

    logic [CUR_W-1:0]   w_cur_in  [LANES];
    logic [TOT_W-1:0]   w_total;
    logic [CUR_W-1:0]   r_cur_d   [LIM_LAT][LANES];
    logic [TOT_W-1:0]   r_tot_d   [LIM_LAT];

    logic [LIM_W-1:0]   w_limit;
    logic               w_scale;
    t_lane_in           r_lane_in [LANES];
    logic               r_scale_d [DIV_STAGES+2];
    logic [CUR_W-1:0]   w_lane_out [LANES];

    logic [CUR_W-1:0]   r_out     [LANES];
    logic               r_out_scaled;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy               <= 1'b1;
            r_vld                <= '0;
            r_cfg.power_cutoff   <= RST_POWER_CUTOFF;
            r_cfg.power_knee     <= RST_POWER_KNEE;
            r_cfg.warning_buffer <= RST_WARNING_BUFFER;
            r_cfg.min_buffer     <= RST_MIN_BUFFER;
            r_cfg.buffer_cl      <= RST_BUFFER_CL;
            r_cfg.power_cl       <= RST_POWER_CL;
            r_cfg.bypass_cl      <= RST_BYPASS_CL;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[OUT_LAT-2:0], w_accept};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POWER_CUTOFF:   r_cfg.power_cutoff   <= i_cfg_wdata[CFG16_W-1:0];
                    CFG_POWER_KNEE:     r_cfg.power_knee     <= i_cfg_wdata[CFG16_W-1:0];
                    CFG_WARNING_BUFFER: r_cfg.warning_buffer <= i_cfg_wdata[CFG16_W-1:0];
                    CFG_MIN_BUFFER:     r_cfg.min_buffer     <= i_cfg_wdata[CFG16_W-1:0];
                    CFG_BUFFER_CL:      r_cfg.buffer_cl      <= i_cfg_wdata[CFG18_W-1:0];
                    CFG_POWER_CL:       r_cfg.power_cl       <= i_cfg_wdata[CFG18_W-1:0];
                    CFG_BYPASS_CL:      r_cfg.bypass_cl      <= i_cfg_wdata[CFG18_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // input commands and their magnitude sum
    always_comb begin
        w_cur_in[0] = i_current_0;
        w_cur_in[1] = i_current_1;
        w_cur_in[2] = i_current_2;
        w_cur_in[3] = i_current_3;
        w_total = '0;
        for (int l = 0; l < LANES; l++) begin
            w_total = w_total + TOT_W'(cpcl_mag(w_cur_in[l]));
        end
    end

    cpcl_limit u_limit (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_power  (i_chassis_power),
        .i_buffer (i_buffer_energy),
        .i_bypass (i_bypass),
        .o_limit  (w_limit)
    );

    // commands and total wait for the limit
    always_ff @(posedge i_clk) begin
        r_tot_d[0] <= w_total;
        for (int l = 0; l < LANES; l++) begin
            r_cur_d[0][l] <= w_cur_in[l];
        end
        for (int s = 1; s < LIM_LAT; s++) begin
            r_tot_d[s] <= r_tot_d[s-1];
            for (int l = 0; l < LANES; l++) begin
                r_cur_d[s][l] <= r_cur_d[s-1][l];
            end
        end
    end

    // merge: compare total with limit and hand each lane its work
    assign w_scale = LIM_W'(r_tot_d[LIM_LAT-1]) > w_limit;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_lane_in[l].scale <= w_scale;
            r_lane_in[l].total <= r_tot_d[LIM_LAT-1];
            r_lane_in[l].lim   <= w_scale ? w_limit[TOT_W-1:0] : '0;
            r_lane_in[l].cur   <= r_cur_d[LIM_LAT-1][l];
        end
        r_scale_d[0] <= w_scale;
        for (int s = 1; s <= DIV_STAGES + 1; s++) begin
            r_scale_d[s] <= r_scale_d[s-1];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cpcl_lane u_lane (
            .i_clk     (i_clk),
            .i_work    (r_lane_in[g]),
            .o_limited (w_lane_out[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_out[l] <= w_lane_out[l];
        end
        r_out_scaled <= r_scale_d[DIV_STAGES+1];
    end

    assign o_valid      = r_vld[OUT_LAT-1];
    assign o_limited_0  = r_out[0];
    assign o_limited_1  = r_out[1];
    assign o_limited_2  = r_out[2];
    assign o_limited_3  = r_out[3];
    assign o_was_scaled = r_out_scaled;

endmodule

`default_nettype wire

### hw/rtl/cpcl_chk.sv
// port-level checker of the current limiter and its bind
`default_nettype none

`include "chassis_power_current_limiter_macros.svh"

module cpcl_chk
    import cpcl_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic signed [CUR_W-1:0] i_current_0,
    input wire logic                    o_valid,
    input wire logic signed [CUR_W-1:0] o_limited_0,
    input wire logic                    o_was_scaled
);

    // busy only shows up around reset
    `CPCL_ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy rose outside reset")

    // every result goes back to a transaction taken a fixed latency earlier
    `CPCL_ASSERT_SAME(a_result_has_start, o_valid, $past(start && !busy, OUT_LAT), "result strobe without a transaction")

    // an unscaled command on lane 0 passes through untouched
    `CPCL_ASSERT_SAME(a_pass_through, o_valid && !o_was_scaled, o_limited_0 == $past(i_current_0, OUT_LAT), "unscaled command changed")

    // scaling never flips the direction of the lane 0 command
    `CPCL_ASSERT_SAME(a_sign_kept, o_valid && o_was_scaled, (o_limited_0 == '0) || (o_limited_0[CUR_W-1] == $past(i_current_0[CUR_W-1], OUT_LAT)), "scaled command flipped sign")

endmodule

bind chassis_power_current_limiter cpcl_chk u_cpcl_chk (.*);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the chassis power current limiter
module tb;
    import cpcl_pkg::*;

    // write to this index must leave every register untouched
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam int MAX_GAP      = 19;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_CMDS   = 100;

    typedef struct packed {
        logic [LANES-1:0][CUR_W-1:0] cmd;
        logic                        scaled;
    } t_limited;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   start;
    logic                   busy;
    logic [PWR_W-1:0]       i_chassis_power;
    logic [PWR_W-1:0]       i_buffer_energy;
    logic                   i_bypass;
    logic signed [CUR_W-1:0] i_current_0;
    logic signed [CUR_W-1:0] i_current_1;
    logic signed [CUR_W-1:0] i_current_2;
    logic signed [CUR_W-1:0] i_current_3;
    logic                   o_valid;
    logic signed [CUR_W-1:0] o_limited_0;
    logic signed [CUR_W-1:0] o_limited_1;
    logic signed [CUR_W-1:0] o_limited_2;
    logic signed [CUR_W-1:0] o_limited_3;
    logic                   o_was_scaled;

    logic [LANES-1:0][CUR_W-1:0] got_cmds;

    t_limited expected_cmds[$];
    t_cfg     cfg_shadow;
    int       gap_max      = 0;
    int       cmd_count    = 0;
    int       bypass_count = 0;
    int       result_count = 0;
    int       scaled_count = 0;
    int       error_count  = 0;
    int       cfg_sets     = 0;
    int       cycle_count  = 0;

    chassis_power_current_limiter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_chassis_power (i_chassis_power),
        .i_buffer_energy (i_buffer_energy),
        .i_bypass        (i_bypass),
        .i_current_0     (i_current_0),
        .i_current_1     (i_current_1),
        .i_current_2     (i_current_2),
        .i_current_3     (i_current_3),
        .o_valid         (o_valid),
        .o_limited_0     (o_limited_0),
        .o_limited_1     (o_limited_1),
        .o_limited_2     (o_limited_2),
        .o_limited_3     (o_limited_3),
        .o_was_scaled    (o_was_scaled)
    );

    assign got_cmds = {o_limited_3, o_limited_2, o_limited_1, o_limited_0};

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // total current limit and per-motor scaling of one transaction
    function automatic t_limited scale_commands(input t_cfg c, input logic [PWR_W-1:0] pwr,
                                                input logic [PWR_W-1:0] nrg, input logic byp,
                                                input logic [LANES-1:0][CUR_W-1:0] cur);
        t_limited        r;
        longint unsigned mag [LANES];
        longint unsigned total;
        longint unsigned lim;
        longint unsigned floor_nrg;
        longint unsigned q;
        total = 0;
        for (int i = 0; i < LANES; i++) begin
            mag[i] = cur[i][CUR_W-1] ? 64'(17'h10000 - {1'b0, cur[i]}) : 64'(cur[i]);
            total += mag[i];
        end
        // limit selection, bypass first, then low buffer, then high power
        if (byp) begin
            lim = 64'(c.bypass_cl);
        end else if (nrg < c.warning_buffer) begin
            floor_nrg = (nrg > c.min_buffer) ? 64'(nrg) : 64'(c.min_buffer);
            lim = (64'(c.buffer_cl) * floor_nrg) / 64'(c.warning_buffer);
        end else if (pwr > c.power_knee && pwr < c.power_cutoff) begin
            lim = 64'(c.buffer_cl) + (64'(c.power_cl) * 64'(c.power_cutoff - pwr))
                  / 64'(c.power_cutoff - c.power_knee);
        end else if (pwr > c.power_knee) begin
            lim = 64'(c.buffer_cl);
        end else begin
            lim = 64'(c.buffer_cl) + 64'(c.power_cl);
        end
        // truncated scaling with the sign kept
        r.scaled = (total > lim);
        for (int i = 0; i < LANES; i++) begin
            if (r.scaled) begin
                q = (mag[i] * lim) / total;
                r.cmd[i] = cur[i][CUR_W-1] ? CUR_W'(64'd0 - q) : CUR_W'(q);
            end else begin
                r.cmd[i] = cur[i];
            end
        end
        return r;
    endfunction

    function automatic logic [LANES-1:0][CUR_W-1:0] motor_cmds(input int a, input int b,
                                                               input int c, input int d);
        logic [LANES-1:0][CUR_W-1:0] v;
        v[0] = CUR_W'(a);
        v[1] = CUR_W'(b);
        v[2] = CUR_W'(c);
        v[3] = CUR_W'(d);
        return v;
    endfunction

    function automatic t_cfg default_regs();
        t_cfg c;
        c.power_cutoff   = RST_POWER_CUTOFF;
        c.power_knee     = RST_POWER_KNEE;
        c.warning_buffer = RST_WARNING_BUFFER;
        c.min_buffer     = RST_MIN_BUFFER;
        c.buffer_cl      = RST_BUFFER_CL;
        c.power_cl       = RST_POWER_CL;
        c.bypass_cl      = RST_BYPASS_CL;
        return c;
    endfunction

    // register values biased toward the ends of their ranges
    function automatic logic [CFG16_W-1:0] pick16(input logic [CFG16_W-1:0] typ);
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return typ;
            3: return CFG16_W'($urandom_range(0, 200));
            default: return CFG16_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG18_W-1:0] pick18(input logic [CFG18_W-1:0] typ);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return typ;
            3: return CFG18_W'($urandom_range(0, 70000));
            default: return CFG18_W'($urandom);
        endcase
    endfunction

    function automatic t_cfg random_regs();
        t_cfg c;
        c.power_cutoff   = pick16(RST_POWER_CUTOFF);
        c.power_knee     = pick16(RST_POWER_KNEE);
        c.warning_buffer = pick16(RST_WARNING_BUFFER);
        c.min_buffer     = pick16(RST_MIN_BUFFER);
        c.buffer_cl      = pick18(RST_BUFFER_CL);
        c.power_cl       = pick18(RST_POWER_CL);
        c.bypass_cl      = pick18(RST_BYPASS_CL);
        return c;
    endfunction

    // send one transaction after a random gap and wait until it is taken
    task automatic send_command(input logic [PWR_W-1:0] pwr, input logic [PWR_W-1:0] nrg,
                                input logic byp, input logic [LANES-1:0][CUR_W-1:0] cur);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_chassis_power <= pwr;
        i_buffer_energy <= nrg;
        i_bypass        <= byp;
        i_current_0     <= cur[0];
        i_current_1     <= cur[1];
        i_current_2     <= cur[2];
        i_current_3     <= cur[3];
        do @(posedge i_clk); while (busy);
        expected_cmds.push_back(scale_commands(cfg_shadow, pwr, nrg, byp, cur));
        cmd_count++;
        if (byp)
            bypass_count++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic pause_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_cmds.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // write the whole register set while the block is idle; upper bits of the
    // 16-bit registers carry junk that must be dropped
    task automatic program_regs(input t_cfg c);
        pause_until_drained();
        write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        write_reg(CFG_POWER_CUTOFF, {2'($urandom_range(0, 3)), c.power_cutoff});
        write_reg(CFG_POWER_KNEE, {2'($urandom_range(0, 3)), c.power_knee});
        write_reg(CFG_WARNING_BUFFER, {2'($urandom_range(0, 3)), c.warning_buffer});
        write_reg(CFG_MIN_BUFFER, {2'($urandom_range(0, 3)), c.min_buffer});
        write_reg(CFG_BUFFER_CL, c.buffer_cl);
        write_reg(CFG_POWER_CL, c.power_cl);
        write_reg(CFG_BYPASS_CL, c.bypass_cl);
        i_cfg_we   <= 1'b0;
        cfg_shadow = c;
        cfg_sets++;
    endtask

    // every limit branch and the field extremes with the reset registers
    task automatic test_reset_defaults();
        gap_max = MAX_GAP;
        send_command(16'd0, 16'd0, 1'b0, motor_cmds(0, 0, 0, 0));
        send_command(16'd0, 16'd0, 1'b1, motor_cmds(-32768, 32767, -32768, 32767));
        send_command(16'd100, 16'd20, 1'b0, motor_cmds(10000, -5000, 3000, -1));
        send_command(16'd100, 16'd3, 1'b0, motor_cmds(-800, 900, -1000, 1100));
        // total equal to the full limit passes unchanged
        send_command(16'd4000, 16'd50, 1'b0, motor_cmds(9000, -9000, 9000, -9000));
        send_command(16'd4001, 16'd50, 1'b0, motor_cmds(9000, -9000, 9000, -9000));
        send_command(16'd7999, 16'd60, 1'b0, motor_cmds(-4002, 4002, 4002, 4000));
        send_command(16'd8000, 16'd60, 1'b0, motor_cmds(4000, 4000, 4000, 4001));
        send_command(16'hFFFF, 16'hFFFF, 1'b0, motor_cmds(-32768, -32768, -32768, -32768));
        gap_max = 0;
        send_command(16'd0, 16'hFFFF, 1'b0, motor_cmds(32767, 32767, 32767, 32767));
        send_command(16'hFFFF, 16'd0, 1'b1, motor_cmds(1, -1, 0, 2));
        send_command(16'h5555, 16'hAAAA, 1'b0, motor_cmds(16'h5555, 16'hAAAA, -1, 1));
    endtask

    // register corner settings: zero warning buffer, min buffer above warning
    // buffer, warning power above power limit, zero and full limits
    task automatic test_register_corners();
        t_cfg c;
        gap_max = MAX_GAP;
        c = default_regs();
        c.warning_buffer = 16'd0;
        c.min_buffer     = 16'hFFFF;
        program_regs(c);
        send_command(16'd0, 16'd0, 1'b0, motor_cmds(32767, -32768, 12000, -3));

        c.warning_buffer = 16'd10;
        c.buffer_cl      = '1;
        c.power_cl       = '1;
        program_regs(c);
        send_command(16'd100, 16'd3, 1'b0, motor_cmds(-32768, -32768, -32768, -32768));

        c.warning_buffer = 16'd1;
        c.buffer_cl      = 18'd1;
        program_regs(c);
        send_command(16'd0, 16'd0, 1'b0, motor_cmds(-32768, 32767, -32768, 32767));

        c = default_regs();
        c.power_cutoff = 16'd1;
        c.power_knee   = 16'hFFFF;
        program_regs(c);
        send_command(16'hFFFF, 16'd60, 1'b0, motor_cmds(20000, 20000, -20000, 1));

        c.power_cutoff = 16'hFFFF;
        c.power_knee   = 16'hFFFE;
        program_regs(c);
        send_command(16'hFFFF, 16'd60, 1'b0, motor_cmds(20000, 20000, -20000, 1));
        send_command(16'hFFFE, 16'd60, 1'b0, motor_cmds(20000, 20000, -20000, 1));

        c.power_knee = 16'd0;
        program_regs(c);
        send_command(16'd1, 16'd60, 1'b0, motor_cmds(20000, 20000, -20000, 1));
        send_command(16'd32768, 16'd60, 1'b0, motor_cmds(20000, 20000, -20000, 1));

        c = default_regs();
        c.buffer_cl = '0;
        c.power_cl  = '0;
        c.bypass_cl = '1;
        program_regs(c);
        send_command(16'd0, 16'd60, 1'b0, motor_cmds(5, -5, 32767, -32768));
        send_command(16'd0, 16'd60, 1'b1, motor_cmds(-32768, -32768, -32768, -32768));
        c.bypass_cl = '0;
        program_regs(c);
        send_command(16'd0, 16'd60, 1'b1, motor_cmds(1, 0, 0, 0));
    endtask

    // random register sets, operating points steered onto the limit branches
    task automatic test_random_traffic();
        int lo;
        int hi;
        int wb;
        int mb;
        logic [PWR_W-1:0] pwr;
        logic [PWR_W-1:0] nrg;
        logic byp;
        logic [LANES-1:0][CUR_W-1:0] cur;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            program_regs((ph == 0) ? default_regs() : random_regs());
            lo = cfg_shadow.power_knee;
            hi = cfg_shadow.power_cutoff;
            wb = cfg_shadow.warning_buffer;
            mb = cfg_shadow.min_buffer;
            for (int n = 0; n < PHASE_CMDS; n++) begin
                if (n % 25 == 0)
                    gap_max = ($urandom_range(0, 1) == 1) ? MAX_GAP : 0;
                if ($urandom_range(0, 39) == 0)
                    pause_until_drained();
                case ($urandom_range(0, 4))
                    0: pwr = PWR_W'($urandom);
                    1: pwr = PWR_W'(lo + $urandom_range(0, 2));
                    2: pwr = PWR_W'(hi - $urandom_range(0, 2));
                    3: pwr = (hi > lo + 1) ? PWR_W'($urandom_range(lo + 1, hi - 1))
                                           : PWR_W'($urandom);
                    default: pwr = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                endcase
                case ($urandom_range(0, 4))
                    0: nrg = PWR_W'($urandom);
                    1: nrg = (wb > 0) ? PWR_W'($urandom_range(0, wb - 1)) : PWR_W'($urandom);
                    2: nrg = PWR_W'(wb - 1 + $urandom_range(0, 2));
                    3: nrg = PWR_W'(mb - 1 + $urandom_range(0, 2));
                    default: nrg = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
                endcase
                byp = ($urandom_range(0, 5) == 0);
                for (int i = 0; i < LANES; i++) begin
                    case ($urandom_range(0, 5))
                        0, 1: cur[i] = CUR_W'($urandom);
                        2: cur[i] = CUR_W'($urandom_range(0, 4000) - 2000);
                        3: cur[i] = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
                        4: cur[i] = '0;
                        default: cur[i] = ($urandom_range(0, 1) == 1)
                                          ? CUR_W'(0 - $urandom_range(8000, 32768))
                                          : CUR_W'($urandom_range(8000, 32767));
                    endcase
                end
                send_command(pwr, nrg, byp, cur);
            end
        end
    endtask

    // compare every result with the oldest outstanding transaction
    always @(posedge i_clk) begin
        t_limited want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (o_was_scaled)
                scaled_count++;
            if (expected_cmds.size() == 0) begin
                error_count++;
                $display("%0t: result with no transaction outstanding", $time);
            end else begin
                want = expected_cmds.pop_front();
                for (int i = 0; i < LANES; i++) begin
                    if (got_cmds[i] !== want.cmd[i]) begin
                        error_count++;
                        $display("%0t: limited_%0d expected %0d got %0d", $time, i,
                                 $signed(want.cmd[i]), $signed(got_cmds[i]));
                    end
                end
                if (o_was_scaled !== want.scaled) begin
                    error_count++;
                    $display("%0t: was_scaled expected %0b got %0b", $time,
                             want.scaled, o_was_scaled);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped by watchdog after %0d cycles", $time, cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_wdata     <= '0;
        start           <= 1'b0;
        i_chassis_power <= '0;
        i_buffer_energy <= '0;
        i_bypass        <= 1'b0;
        i_current_0     <= '0;
        i_current_1     <= '0;
        i_current_2     <= '0;
        i_current_3     <= '0;
        cfg_shadow      = default_regs();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_corners();
        test_random_traffic();

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d commands (%0d bypassed) over %0d register sets", cmd_count,
                 bypass_count, cfg_sets);
        $display("checked %0d results, %0d of them scaled down", result_count, scaled_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
